>>> design/bsk_pkg.sv
package bsk_pkg;

  localparam int COORD_W = 9;
  localparam int STEP_W  = 16;
  localparam int PROD_W  = COORD_W + STEP_W;
  localparam int CH_W    = 8;
  localparam int PX_W    = 3 * CH_W;
  localparam int DIM_W   = 10;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP_Q12      = 2'd2;

  localparam logic [DIM_W-1:0]  SOURCE_WIDTH_RST  = 10'd512;
  localparam logic [DIM_W-1:0]  SOURCE_HEIGHT_RST = 10'd512;
  localparam logic [STEP_W-1:0] STEP_Q12_RST      = 16'd6628;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  localparam logic [PX_W-1:0] KEY_GREEN = 24'h00FF00;
  localparam logic [CH_W-1:0] CH_MAX    = 8'd255;

  // one neighbour read in flight toward the blend stage
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tap_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            keyed;
  } px_out_t;

endpackage

>>> design/bsk_in_if.sv
interface bsk_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [bsk_pkg::COORD_W-1:0]  col;
  logic [bsk_pkg::COORD_W-1:0]  row;
  logic [bsk_pkg::CH_W-1:0]     in_red;
  logic [bsk_pkg::CH_W-1:0]     in_green;
  logic [bsk_pkg::CH_W-1:0]     in_blue;

  modport source (output valid, func, col, row, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, func, col, row, in_red, in_green, in_blue, output ready);
endinterface

>>> design/bsk_out_if.sv
interface bsk_out_if;
  logic                      valid;
  logic                      ready;
  logic [bsk_pkg::CH_W-1:0]  out_red;
  logic [bsk_pkg::CH_W-1:0]  out_green;
  logic [bsk_pkg::CH_W-1:0]  out_blue;
  logic                      keyed;

  modport source (output valid, out_red, out_green, out_blue, keyed, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, keyed, output ready);
endinterface

>>> design/bsk_ram.sv
module bsk_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> design/bsk_fetch.sv
module bsk_fetch #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                           clk,
  input  logic                                           rst,
  bsk_in_if.sink                                         req,
  input  logic [bsk_pkg::STEP_W-1:0]                     step,
  input  logic [$clog2(MAX_WIDTH)-1:0]                   wm2,
  input  logic [$clog2(MAX_HEIGHT)-1:0]                  hm2,
  input  logic                                           room,
  output logic                                           ram_en,
  output logic                                           ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]        ram_addr,
  output logic [bsk_pkg::PX_W-1:0]                       ram_wdata,
  output bsk_pkg::tap_t                                  tap,
  output logic [2*FRAC_BITS:0]                           wt
);
  import bsk_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int AWD  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CXW  = (PROD_W > XW + FRAC_BITS) ? PROD_W : XW + FRAC_BITS;
  localparam int CYW  = (PROD_W > YW + FRAC_BITS) ? PROD_W : YW + FRAC_BITS;
  localparam int WXW  = FRAC_BITS + 1;
  localparam int WPW  = 2 * FRAC_BITS + 2;
  localparam int WTW  = 2 * FRAC_BITS + 1;
  localparam logic [1:0]     LAST_K = 2'd3;
  localparam logic [WXW-1:0] ONE    = {1'b1, {FRAC_BITS{1'b0}}};

  // input register: coordinate products
  logic                 s1_vld;
  logic                 s1_func;
  logic                 s1_ok;
  logic [COORD_W-1:0]   s1_col;
  logic [COORD_W-1:0]   s1_row;
  logic [PX_W-1:0]      s1_px;
  logic [PROD_W-1:0]    s1_xx;
  logic [PROD_W-1:0]    s1_yy;

  // read sequencer
  logic                 s2_busy;
  logic [1:0]           s2_k;
  logic [XW-1:0]        s2_a;
  logic [YW-1:0]        s2_b;
  logic [FRAC_BITS-1:0] s2_fx;
  logic [FRAC_BITS-1:0] s2_fy;

  logic                 s2_free;
  logic                 s2_load;
  logic                 s1_move;
  logic                 accept;
  logic [CXW-1:0]       xx_e;
  logic [CXW-1:0]       limx;
  logic [CYW-1:0]       yy_e;
  logic [CYW-1:0]       limy;
  logic [XW-1:0]        a_next;
  logic [YW-1:0]        b_next;
  logic [FRAC_BITS-1:0] fx_next;
  logic [FRAC_BITS-1:0] fy_next;
  logic [XW-1:0]        col_sel;
  logic [YW-1:0]        row_sel;
  logic [WXW-1:0]       wx;
  logic [WXW-1:0]       wy;
  logic [WPW-1:0]       wprod;

  assign accept  = req.valid && req.ready;
  assign s2_free = !s2_busy || (s2_k == LAST_K);
  assign s2_load = s1_vld && (s1_func == FUNC_COMPUTE) && s2_free && room;
  assign s1_move = s2_load || (s1_vld && (s1_func == FUNC_WRITE) && !s2_busy);
  assign req.ready = !s1_vld || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (accept) begin
      s1_vld <= 1'b1;
    end else if (s1_move) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= req.func;
      s1_ok   <= (int'(req.col) < MAX_WIDTH) && (int'(req.row) < MAX_HEIGHT);
      s1_col  <= req.col;
      s1_row  <= req.row;
      s1_px   <= {req.in_red, req.in_green, req.in_blue};
      s1_xx   <= PROD_W'(req.col) * PROD_W'(step);
      s1_yy   <= PROD_W'(req.row) * PROD_W'(step);
    end
  end

  // clamp integer part to size-2; a clamped coordinate has no fraction
  always_comb begin
    xx_e = CXW'(s1_xx);
    yy_e = CYW'(s1_yy);
    limx = CXW'({wm2, {FRAC_BITS{1'b0}}});
    limy = CYW'({hm2, {FRAC_BITS{1'b0}}});
    if (xx_e > limx) begin
      a_next  = wm2;
      fx_next = '0;
    end else begin
      a_next  = XW'(xx_e >> FRAC_BITS);
      fx_next = xx_e[FRAC_BITS-1:0];
    end
    if (yy_e > limy) begin
      b_next  = hm2;
      fy_next = '0;
    end else begin
      b_next  = YW'(yy_e >> FRAC_BITS);
      fy_next = yy_e[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_busy <= 1'b0;
      s2_k    <= 2'd0;
    end else if (s2_load) begin
      s2_busy <= 1'b1;
      s2_k    <= 2'd0;
    end else if (s2_busy) begin
      s2_k <= s2_k + 2'd1;
      if (s2_k == LAST_K) begin
        s2_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_a  <= a_next;
      s2_b  <= b_next;
      s2_fx <= fx_next;
      s2_fy <= fy_next;
    end
  end

  // k[0] steps right, k[1] steps down
  assign col_sel   = s2_busy ? s2_a + XW'(s2_k[0]) : XW'(s1_col);
  assign row_sel   = s2_busy ? s2_b + YW'(s2_k[1]) : YW'(s1_row);
  assign ram_addr  = AWD'(row_sel) * AWD'(MAX_WIDTH) + AWD'(col_sel);
  assign ram_we    = s1_vld && (s1_func == FUNC_WRITE) && !s2_busy && s1_ok;
  assign ram_en    = s2_busy || ram_we;
  assign ram_wdata = s1_px;

  assign wx    = s2_k[0] ? {1'b0, s2_fx} : ONE - {1'b0, s2_fx};
  assign wy    = s2_k[1] ? {1'b0, s2_fy} : ONE - {1'b0, s2_fy};
  assign wprod = WPW'(wx) * WPW'(wy);

  // aligned with the registered RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else begin
      tap.vld   <= s2_busy;
      tap.first <= (s2_k == 2'd0);
      tap.last  <= (s2_k == LAST_K);
    end
  end

  always_ff @(posedge clk) begin
    wt <= wprod[WTW-1:0];
  end

  a_hold_port: assert property (@(posedge clk) disable iff (rst)
    s2_busy && (s2_k != LAST_K) |=> s2_busy)
    else $error("read sequence left the port early");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    s2_load |-> !s2_busy || (s2_k == LAST_K))
    else $error("compute loaded over a running read sequence");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == FUNC_COMPUTE) |=> s1_vld && (s1_func == FUNC_COMPUTE))
    else $error("accepted compute beat not held in input register");

endmodule

>>> design/bsk_blend.sv
module bsk_blend #(
  parameter int FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsk_pkg::tap_t              tap,
  input  logic [2*FRAC_BITS:0]       wt,
  input  logic [bsk_pkg::PX_W-1:0]   rdata,
  output logic                       room,
  bsk_out_if.source                  rsp
);
  import bsk_pkg::*;

  localparam int AW = 2 * FRAC_BITS + CH_W + 1;
  localparam int QW = AW - 2 * FRAC_BITS;
  localparam logic [1:0] QDEPTH = 2'd2;

  logic          key;
  logic          done;
  logic [AW-1:0] pr_r;
  logic [AW-1:0] pr_g;
  logic [AW-1:0] pr_b;
  logic [AW-1:0] acc_r;
  logic [AW-1:0] acc_g;
  logic [AW-1:0] acc_b;
  logic [AW-1:0] acc_rn;
  logic [AW-1:0] acc_gn;
  logic [AW-1:0] acc_bn;
  logic          is_key;
  logic [QW-1:0] q_r;
  logic [QW-1:0] q_g;
  logic [QW-1:0] q_b;
  px_out_t       res;

  px_out_t       fifo [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic [1:0]    cred;
  logic          push;
  logic          pop;
  logic          start;

  assign is_key = (rdata == KEY_GREEN);
  assign pr_r = AW'(rdata[23:16]) * AW'(wt);
  assign pr_g = AW'(rdata[15:8])  * AW'(wt);
  assign pr_b = AW'(rdata[7:0])   * AW'(wt);
  assign acc_rn = tap.first ? pr_r : acc_r + pr_r;
  assign acc_gn = tap.first ? pr_g : acc_g + pr_g;
  assign acc_bn = tap.first ? pr_b : acc_b + pr_b;

  always_ff @(posedge clk) begin
    if (tap.vld) begin
      acc_r <= acc_rn;
      acc_g <= acc_gn;
      acc_b <= acc_bn;
      key   <= tap.first ? is_key : (key | is_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tap.vld && tap.last;
    end
  end

  assign q_r = QW'(acc_r >> (2 * FRAC_BITS));
  assign q_g = QW'(acc_g >> (2 * FRAC_BITS));
  assign q_b = QW'(acc_b >> (2 * FRAC_BITS));

  always_comb begin
    if (key) begin
      res.red   = '0;
      res.green = CH_MAX;
      res.blue  = '0;
      res.keyed = 1'b1;
    end else begin
      res.red   = (q_r > QW'(CH_MAX)) ? CH_MAX : q_r[CH_W-1:0];
      res.green = (q_g > QW'(CH_MAX)) ? CH_MAX : q_g[CH_W-1:0];
      res.blue  = (q_b > QW'(CH_MAX)) ? CH_MAX : q_b[CH_W-1:0];
      res.keyed = 1'b0;
    end
  end

  // result queue; credits cover every compute from first read to pop
  assign push  = done;
  assign pop   = rsp.valid && rsp.ready;
  assign start = tap.vld && tap.first;
  assign room  = (cred < QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      cnt  <= 2'd0;
      cred <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt  <= cnt + 2'(push) - 2'(pop);
      cred <= cred + 2'(start) - 2'(pop);
    end
  end

  assign rsp.valid     = (cnt != 2'd0);
  assign rsp.out_red   = fifo[rp].red;
  assign rsp.out_green = fifo[rp].green;
  assign rsp.out_blue  = fifo[rp].blue;
  assign rsp.keyed     = fifo[rp].keyed;

  a_start_has_credit: assert property (@(posedge clk) disable iff (rst)
    start |-> cred != QDEPTH)
    else $error("compute started without queue space");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt != QDEPTH) || pop)
    else $error("result queue overflow");

  a_cnt_within_cred: assert property (@(posedge clk) disable iff (rst)
    cnt <= cred)
    else $error("queued results exceed outstanding credits");

endmodule

>>> design/bilinear_scaler_with_color_key_unit.sv
// Write beat: held in the input register, then written to the frame memory; one write beat per
// cycle while no neighbour reads hold the port. Compute beat: a new compute loads, given queue
// room, with the last of the four reads of the one before through the single memory port.
// A write that follows a compute waits for that compute's reads to finish.
// Reset (rst, synchronous) clears control state and loads the register reset values;
// the frame memory is not cleared and holds no data until written.
module bilinear_scaler_with_color_key_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [bsk_pkg::IDX_W-1:0]   cfg_idx,
  input  logic [bsk_pkg::CFG_W-1:0]   cfg_wdata,
  bsk_in_if.sink                      req,
  bsk_out_if.source                   rsp
);
  import bsk_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int AWD = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [DIM_W-1:0]  source_width;
  logic [DIM_W-1:0]  source_height;
  logic [STEP_W-1:0] step_q12;
  logic [XW-1:0]     wm2;
  logic [YW-1:0]     hm2;

  logic              room;
  logic              ram_en;
  logic              ram_we;
  logic [AWD-1:0]    ram_addr;
  logic [PX_W-1:0]   ram_wdata;
  logic [PX_W-1:0]   ram_rdata;
  tap_t              tap;
  logic [2*FRAC_BITS:0] wt;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RST;
      source_height <= SOURCE_HEIGHT_RST;
      step_q12      <= STEP_Q12_RST;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_SOURCE_WIDTH:  source_width  <= cfg_wdata[DIM_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_wdata[DIM_W-1:0];
        REG_STEP_Q12:      step_q12      <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size less two, with the size held to [2, MAX]
  always_ff @(posedge clk) begin
    if (source_width < DIM_W'(2)) begin
      wm2 <= '0;
    end else if (int'(source_width) > MAX_WIDTH) begin
      wm2 <= XW'(MAX_WIDTH - 2);
    end else begin
      wm2 <= XW'(source_width - DIM_W'(2));
    end
    if (source_height < DIM_W'(2)) begin
      hm2 <= '0;
    end else if (int'(source_height) > MAX_HEIGHT) begin
      hm2 <= YW'(MAX_HEIGHT - 2);
    end else begin
      hm2 <= YW'(source_height - DIM_W'(2));
    end
  end

  bsk_fetch #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fetch (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .step      (step_q12),
    .wm2       (wm2),
    .hm2       (hm2),
    .room      (room),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .tap       (tap),
    .wt        (wt)
  );

  bsk_ram #(
    .WIDTH (PX_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bsk_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk   (clk),
    .rst   (rst),
    .tap   (tap),
    .wt    (wt),
    .rdata (ram_rdata),
    .room  (room),
    .rsp   (rsp)
  );

endmodule

>>> verif/bilinear_scaler_with_color_key_unit_tb.sv
module bilinear_scaler_with_color_key_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsk_pkg::*;

  localparam int FRAC        = 12;
  localparam int ONE_Q       = 1 << FRAC;
  localparam int FRAME_W     = 512;
  localparam int FRAME_H     = 512;
  localparam int PHASE_ITEMS = 90;
  localparam int TOTAL_ITEMS = 800;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  class scaler_scoreboard;
    bit [PX_W-1:0]   frame_px [int];
    bit [DIM_W-1:0]  width_q;
    bit [DIM_W-1:0]  height_q;
    bit [STEP_W-1:0] step_q;
    px_out_t         expected_px [$];
    bit              failed;

    function new();
      width_q  = SOURCE_WIDTH_RST;
      height_q = SOURCE_HEIGHT_RST;
      step_q   = STEP_Q12_RST;
      failed   = 1'b0;
    endfunction

    function void load_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SOURCE_WIDTH:  width_q  = data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: height_q = data[DIM_W-1:0];
        REG_STEP_Q12:      step_q   = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // top-left neighbour and Q.12 fractions of a destination pixel
    function void locate(input logic [COORD_W-1:0] col, row,
                         output int ax, by, fx, fy);
      longint unsigned w, h, xx, yy, lim;
      w  = (width_q < 2) ? 2 : (width_q > FRAME_W) ? FRAME_W : width_q;
      h  = (height_q < 2) ? 2 : (height_q > FRAME_H) ? FRAME_H : height_q;
      xx = col;
      xx = xx * step_q;
      yy = row;
      yy = yy * step_q;
      lim = (w - 2) << FRAC;
      if (xx > lim) xx = lim;
      lim = (h - 2) << FRAC;
      if (yy > lim) yy = lim;
      ax = int'(xx >> FRAC);
      by = int'(yy >> FRAC);
      fx = int'(xx & (ONE_Q - 1));
      fy = int'(yy & (ONE_Q - 1));
    endfunction

    function bit has_px(int x, int y);
      return frame_px.exists(y * FRAME_W + x);
    endfunction

    function bit [CH_W-1:0] blend_channel(bit [PX_W-1:0] nb [4],
                                          longint unsigned wt [4], int k);
      longint unsigned acc;
      acc = 0;
      for (int i = 0; i < 4; i++) acc += nb[i][8*k +: 8] * wt[i];
      acc >>= 2 * FRAC;
      return (acc > CH_MAX) ? CH_MAX : acc[CH_W-1:0];
    endfunction

    function void note_request(logic fn, logic [COORD_W-1:0] col, row,
                               logic [PX_W-1:0] px);
      int ax, by, fx, fy;
      bit [PX_W-1:0] nb [4];
      longint unsigned wt [4];
      px_out_t want;
      if (fn == FUNC_WRITE) begin
        frame_px[row * FRAME_W + col] = px;
        return;
      end
      locate(col, row, ax, by, fx, fy);
      for (int i = 0; i < 4; i++) nb[i] = frame_px[(by + i / 2) * FRAME_W + ax + i % 2];
      wt[0] = (ONE_Q - fx) * (ONE_Q - fy);
      wt[1] = fx * (ONE_Q - fy);
      wt[2] = (ONE_Q - fx) * fy;
      wt[3] = fx * fy;
      want.keyed = 1'b0;
      foreach (nb[i]) if (nb[i] == KEY_GREEN) want.keyed = 1'b1;
      if (want.keyed) begin
        want.red   = '0;
        want.green = CH_MAX;
        want.blue  = '0;
      end else begin
        want.red   = blend_channel(nb, wt, 2);
        want.green = blend_channel(nb, wt, 1);
        want.blue  = blend_channel(nb, wt, 0);
      end
      expected_px.push_back(want);
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        failed = 1'b1;
      end
    endfunction

    function void check_pixel(logic [CH_W-1:0] r, g, b, logic k);
      px_out_t want;
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got red %0d green %0d blue %0d keyed %0d",
                 $time, r, g, b, k);
        failed = 1'b1;
        return;
      end
      want = expected_px.pop_front();
      compare_field("red", want.red, r);
      compare_field("green", want.green, g);
      compare_field("blue", want.blue, b);
      compare_field("keyed", want.keyed, k);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wen;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  bsk_in_if  req_bus ();
  bsk_out_if rsp_bus ();

  scaler_scoreboard sb = new();

  int item_count = 0;
  int src_left   = 0;
  int dst_left   = 0;
  bit src_calm   = 1'b0;
  bit dst_calm   = 1'b0;

  bilinear_scaler_with_color_key_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles before a beat; now and then a stretch with none at all
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(8, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [PX_W-1:0] rand_px();
    case ($urandom_range(0, 11))
      0: return KEY_GREEN;
      1: return KEY_GREEN ^ (24'd1 << $urandom_range(0, 23));
      2: return '1;
      3: return '0;
      default: return PX_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return DIM_W'($urandom_range(0, 1));
      1: return DIM_W'($urandom_range(513, 1023));
      2: return DIM_W'(FRAME_W);
      default: return DIM_W'($urandom_range(2, 48));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom);
      default: return STEP_W'($urandom_range(1, 8192));
    endcase
  endfunction

  task automatic send_item(input logic fn, input logic [COORD_W-1:0] col, row,
                           input logic [PX_W-1:0] px);
    int gap;
    gap = draw_wait(src_left, src_calm);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.func     <= fn;
    req_bus.col      <= col;
    req_bus.row      <= row;
    req_bus.in_red   <= px[23:16];
    req_bus.in_green <= px[15:8];
    req_bus.in_blue  <= px[7:0];
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(fn, col, row, px);
    item_count++;
  endtask

  // fill any neighbour never written, then issue the compute beat
  task automatic send_compute(input logic [COORD_W-1:0] col, row);
    int ax, by, fx, fy;
    sb.locate(col, row, ax, by, fx, fy);
    for (int i = 0; i < 4; i++)
      if (!sb.has_px(ax + i % 2, by + i / 2))
        send_item(FUNC_WRITE, COORD_W'(ax + i % 2), COORD_W'(by + i / 2), rand_px());
    send_item(FUNC_COMPUTE, col, row, PX_W'($urandom));
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_config(input logic [DIM_W-1:0] w, h, input logic [STEP_W-1:0] s);
    logic [IDX_W-1:0] idx [4];
    logic [CFG_W-1:0] data [4];
    idx  = '{REG_UNUSED, REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_STEP_Q12};
    data = '{CFG_W'($urandom), {6'($urandom), w}, {6'($urandom), h}, s};
    for (int i = 0; i < 4; i++) begin
      cfg_wen   <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= data[i];
      sb.load_reg(idx[i], data[i]);
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  // mostly small rasters of neighbouring computes, some stray writes and scattered computes
  task automatic run_traffic(input int quota);
    int stop_at, k;
    logic [COORD_W-1:0] c0, c, r;
    stop_at = item_count + quota;
    c0 = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 511))
                              : COORD_W'($urandom_range(0, 24));
    r  = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 511))
                              : COORD_W'($urandom_range(0, 24));
    c  = c0;
    k  = 0;
    while (item_count < stop_at) begin
      case ($urandom_range(0, 7))
        0: send_item(FUNC_WRITE, COORD_W'($urandom), COORD_W'($urandom), rand_px());
        1: send_compute(COORD_W'($urandom), COORD_W'($urandom));
        default: begin
          send_compute(c, r);
          c++;
          k++;
          if (k == 6) begin
            k = 0;
            c = c0;
            r++;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      sb.check_pixel(rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue, rsp_bus.keyed);
  end

  initial begin : rsp_drain
    int stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(dst_left, dst_calm);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  initial begin : stimulus
    int phase;
    rst              <= 1'b1;
    cfg_wen          <= 1'b0;
    cfg_idx          <= REG_SOURCE_WIDTH;
    cfg_wdata        <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.func     <= FUNC_WRITE;
    req_bus.col      <= '0;
    req_bus.row      <= '0;
    req_bus.in_red   <= '0;
    req_bus.in_green <= '0;
    req_bus.in_blue  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset register values: corners, far-corner clamp, green key and near misses
    send_item(FUNC_WRITE, 0, 0, 24'hFFFFFF);
    send_item(FUNC_WRITE, 1, 0, 24'h000000);
    send_item(FUNC_WRITE, 0, 1, 24'hFF00FF);
    send_item(FUNC_WRITE, 1, 1, 24'h00FF01);
    send_compute(0, 0);
    send_compute(1, 1);
    send_compute(9'd511, 9'd511);
    send_item(FUNC_WRITE, 0, 0, KEY_GREEN);
    send_compute(0, 0);
    send_item(FUNC_WRITE, 0, 0, 24'h01FF00);
    send_compute(0, 0);
    send_item(FUNC_WRITE, 1, 1, 24'h00FE00);
    send_compute(0, 0);
    settle();

    phase = 1;
    while (item_count < TOTAL_ITEMS) begin
      case (phase)
        1: load_config(10'd2, 10'd2, 16'd0);
        2: load_config(10'd1023, 10'd512, 16'hFFFF);
        3: load_config(10'd0, 10'd1, 16'd1);
        4: load_config(10'd513, 10'd3, 16'd4096);
        default: load_config(pick_dim(), pick_dim(), pick_step());
      endcase
      run_traffic(PHASE_ITEMS);
      settle();
      phase++;
    end

    if (!sb.failed)
      $display("bilinear_scaler_with_color_key_unit: match");
    else
      $display("bilinear_scaler_with_color_key_unit: mismatch");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("bilinear_scaler_with_color_key_unit: mismatch");
    $finish;
  end

endmodule
